### rtl/core/gdau_pkg.sv
// ----------------------------------------------------------------------------
// gdau_pkg
// Types, constants and calendar helper functions shared by the Gregorian
// date arithmetic unit.
// ----------------------------------------------------------------------------
package gdau_pkg;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CNT_W   = 22;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned ST_W    = 2;

  // Day numbers and internal years cover every year up to 65535 plus the
  // largest day count.
  localparam int unsigned G_W  = 26;
  localparam int unsigned IY_W = 17;
  localparam int unsigned RS_W = 9;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned YEAR_FIELD_MAX = (1 << YEAR_W) - 1;

  // floor(x / 25) as (x * 5243) >> 17, exact for x below 43690.
  localparam int unsigned D25_RECIP = 5243;
  localparam int unsigned D25_SHIFT = 17;

  // Year estimate: floor(g * YR_RECIP / 2^32), within one of the true year.
  localparam int unsigned YR_RECIP_W = 24;
  localparam logic [YR_RECIP_W-1:0] YR_RECIP = 24'd11759193;
  localparam int unsigned YR_SHIFT = 32;

  // floor(x / 7) as (x * WK_RECIP) >> 32, exact for x below 2^26.
  localparam int unsigned WK_RECIP_W = 30;
  localparam logic [WK_RECIP_W-1:0] WK_RECIP = 30'd613566757;
  localparam int unsigned WK_SHIFT = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_WEEKDAY = 2'd0,
    FN_DIFF    = 2'd1,
    FN_ADD     = 2'd2
  } func_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    logic              vld;
    logic              bad;
    logic [FUNC_W-1:0] func;
  } ctl_t;

  function automatic logic [IY_W-1:0] div100(input logic [IY_W-1:0] y);
    logic [IY_W+12:0] p;
    p = (IY_W+13)'(y >> 2) * (IY_W+13)'(D25_RECIP);
    return IY_W'(p >> D25_SHIFT);
  endfunction

  // Days from the start of shifted year 0 to the start of shifted year y.
  function automatic logic [G_W-1:0] year_base(input logic [IY_W-1:0] y);
    logic [IY_W-1:0] q;
    q = div100(y);
    return G_W'(G_W'(y) * G_W'(DAYS_PER_YEAR)) + G_W'(y >> 2) - G_W'(q) + G_W'(q >> 2);
  endfunction

  function automatic logic is_leap(input logic [IY_W-1:0] y);
    logic [IY_W-1:0] q;
    logic            whole;
    q     = div100(y);
    whole = (y == IY_W'(q * 7'd100));
    return (y[1:0] == 2'd0) && (!whole || (q[1:0] == 2'd0));
  endfunction

  // First day offset of each shifted month, March being month 0.
  function automatic logic [RS_W-1:0] month_start(input logic [MONTH_W-1:0] mi);
    logic [RS_W-1:0] s;
    case (mi)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     l = 5'd30;
      4'd2:                                        l = 5'd28;
      default:                                     l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic logic date_ok(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                                   input logic [DAY_W-1:0] d, input logic [IY_W-1:0] ymax);
    logic [DAY_W-1:0] len;
    len = month_len(m);
    if (m == 4'd2 && is_leap(IY_W'(y))) begin
      len = 5'd29;
    end
    return (y != '0) && (IY_W'(y) <= ymax) && (m >= 4'd1) && (m <= 4'd12) &&
           (d != '0) && (d <= len);
  endfunction

  function automatic logic [G_W-1:0] day_number(input logic [YEAR_W-1:0] y,
                                                input logic [MONTH_W-1:0] m,
                                                input logic [DAY_W-1:0] d);
    logic [MONTH_W-1:0] mp;
    logic [IY_W-1:0]    yp;
    mp = (m >= 4'd3) ? MONTH_W'(m - 4'd3) : MONTH_W'(m + 4'd9);
    yp = IY_W'(y) - {{(IY_W-1){1'b0}}, (m < 4'd3)};
    return year_base(yp) + G_W'(month_start(mp)) + G_W'(d) - G_W'(1);
  endfunction

endpackage

### rtl/core/gdau_fwd.sv
// ----------------------------------------------------------------------------
// gdau_fwd
// First pipeline stage: checks both input dates and maps them to day numbers.
// ----------------------------------------------------------------------------
module gdau_fwd import gdau_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [FUNC_W-1:0]  func,
  input  logic [YEAR_W-1:0]  year_a,
  input  logic [MONTH_W-1:0] month_a,
  input  logic [DAY_W-1:0]   day_a,
  input  logic [YEAR_W-1:0]  year_b,
  input  logic [MONTH_W-1:0] month_b,
  input  logic [DAY_W-1:0]   day_b,
  input  logic [CNT_W-1:0]   day_count,
  output ctl_t               ctl_r,
  output logic [G_W-1:0]     ga_r,
  output logic [G_W-1:0]     gb_r,
  output logic [CNT_W-1:0]   cnt_r
);

  localparam logic [IY_W-1:0] YMAX = IY_W'(MAX_YEAR);

  ctl_t           ctl_nxt;
  logic           ok_a;
  logic           ok_b;
  logic [G_W-1:0] ga_nxt;
  logic [G_W-1:0] gb_nxt;

  always_comb begin
    ok_a         = date_ok(year_a, month_a, day_a, YMAX);
    ok_b         = date_ok(year_b, month_b, day_b, YMAX);
    ga_nxt       = day_number(year_a, month_a, day_a);
    gb_nxt       = day_number(year_b, month_b, day_b);
    ctl_nxt.vld  = in_vld;
    ctl_nxt.func = func;
    ctl_nxt.bad  = !((func == FN_WEEKDAY) || (func == FN_DIFF) || (func == FN_ADD)) ||
                   !ok_a || ((func == FN_DIFF) && !ok_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_nxt.vld;
    end
    ctl_r.bad  <= ctl_nxt.bad;
    ctl_r.func <= ctl_nxt.func;
    ga_r       <= ga_nxt;
    gb_r       <= gb_nxt;
    cnt_r      <= day_count;
  end

endmodule

### rtl/core/gdau_inv.sv
// ----------------------------------------------------------------------------
// gdau_inv
// Four-stage conversion of a day number back to a calendar date: year
// estimate, candidate year bases, year selection, month and day split.
// ----------------------------------------------------------------------------
module gdau_inv import gdau_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [G_W-1:0]     g,
  output logic               out_vld,
  output logic [IY_W-1:0]    out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day,
  output logic               out_ovf
);

  localparam logic [IY_W-1:0] YMAX = IY_W'(MAX_YEAR);
  localparam logic [IY_W-1:0] YFLD = IY_W'(YEAR_FIELD_MAX);

  logic [3:0] vld_r;

  logic [G_W+YR_RECIP_W-1:0] est_prod;
  logic [IY_W-1:0]           e1_nxt, e1_r;
  logic [G_W-1:0]            g1_r;

  logic [G_W-1:0]  b0_nxt, b0_r, b1_nxt, b1_r;
  logic            lp_nxt, lp_r;
  logic [IY_W-1:0] e2_r;
  logic [G_W-1:0]  g2_r;

  logic [IY_W-1:0] yy3_nxt, yy3_r;
  logic [G_W-1:0]  base3;
  logic [RS_W-1:0] rem3_nxt, rem3_r;

  logic [MONTH_W-1:0] mi;
  logic [IY_W-1:0]    year_nxt;
  logic [MONTH_W-1:0] month_nxt;
  logic [DAY_W-1:0]   day_nxt;
  logic               ovf_nxt;

  always_comb begin
    est_prod = (G_W+YR_RECIP_W)'(g) * (G_W+YR_RECIP_W)'(YR_RECIP);
    e1_nxt   = IY_W'(est_prod >> YR_SHIFT);
  end

  always_comb begin
    b0_nxt = year_base(e1_r);
    b1_nxt = year_base(e1_r + IY_W'(1));
    lp_nxt = is_leap(e1_r);
  end

  always_comb begin
    if (g2_r < b0_r) begin
      yy3_nxt = e2_r - IY_W'(1);
      base3   = b0_r - G_W'(DAYS_PER_YEAR) - G_W'(lp_r);
    end else if (g2_r >= b1_r) begin
      yy3_nxt = e2_r + IY_W'(1);
      base3   = b1_r;
    end else begin
      yy3_nxt = e2_r;
      base3   = b0_r;
    end
    rem3_nxt = RS_W'(g2_r - base3);
  end

  always_comb begin
    mi = '0;
    for (int k = 1; k < 12; k++) begin
      mi = mi + MONTH_W'(rem3_r >= month_start(MONTH_W'(k)));
    end
    if (mi < 4'd10) begin
      month_nxt = mi + 4'd3;
      year_nxt  = yy3_r;
    end else begin
      month_nxt = mi - 4'd9;
      year_nxt  = yy3_r + IY_W'(1);
    end
    day_nxt = DAY_W'(rem3_r - month_start(mi) + RS_W'(1));
    ovf_nxt = (year_nxt > YMAX) || (year_nxt > YFLD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    e1_r      <= e1_nxt;
    g1_r      <= g;
    b0_r      <= b0_nxt;
    b1_r      <= b1_nxt;
    lp_r      <= lp_nxt;
    e2_r      <= e1_r;
    g2_r      <= g1_r;
    yy3_r     <= yy3_nxt;
    rem3_r    <= rem3_nxt;
    out_year  <= year_nxt;
    out_month <= month_nxt;
    out_day   <= day_nxt;
    out_ovf   <= ovf_nxt;
  end

  assign out_vld = vld_r[3];

endmodule

### rtl/core/gregorian_date_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// Gregorian date unit: weekday of a date, day difference of two dates and
// date plus a day count, with invalid dates and year overflow flagged.
//
//   Channel   Ports                                   Handshake
//   request   in_func, in_year_a .. in_day_count      start, taken when !busy
//   result    out_weekday .. out_status               out_valid, one cycle
//
// A request is taken in any cycle and its result comes out of the
// seven-stage pipeline, mostly the four-stage conversion of a day
// number back to a date. One beat enters per cycle.
// busy stays low, since the receiver cannot stall the result.
// rst_n clears all valid bits synchronously.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit import gdau_pkg::*; #(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [YEAR_W-1:0]        in_year_a,
  input  logic [MONTH_W-1:0]       in_month_a,
  input  logic [DAY_W-1:0]         in_day_a,
  input  logic [YEAR_W-1:0]        in_year_b,
  input  logic [MONTH_W-1:0]       in_month_b,
  input  logic [DAY_W-1:0]         in_day_b,
  input  logic [CNT_W-1:0]         in_day_count,
  output logic                     out_valid,
  output logic [WD_W-1:0]          out_weekday,
  output logic signed [DIFF_W-1:0] out_day_difference,
  output logic [YEAR_W-1:0]        out_result_year,
  output logic [MONTH_W-1:0]       out_result_month,
  output logic [DAY_W-1:0]         out_result_day,
  output logic [ST_W-1:0]          out_status
);

  localparam int unsigned WP_W = G_W + WK_RECIP_W;

  ctl_t             ctl1;
  logic [G_W-1:0]   ga1, gb1;
  logic [CNT_W-1:0] cnt1;

  ctl_t             ctl_r [2:6];
  logic [G_W-1:0]   g2_r;
  logic [G_W-1:0]   wx2_r, wx3_r;
  logic [DIFF_W-1:0] diff_r [2:6];
  logic [WP_W-1:0]  wk_prod;
  logic [G_W-1:0]   q7_nxt, q7_r;
  logic [WD_W-1:0]  wd4_nxt;
  logic [WD_W-1:0]  wd_r [4:6];

  logic               inv_vld;
  logic [IY_W-1:0]    inv_year;
  logic [MONTH_W-1:0] inv_month;
  logic [DAY_W-1:0]   inv_day;
  logic               inv_ovf;

  logic               vld_nxt;
  logic [WD_W-1:0]    wd_nxt;
  logic [DIFF_W-1:0]  diff_nxt;
  logic [YEAR_W-1:0]  ry_nxt;
  logic [MONTH_W-1:0] rm_nxt;
  logic [DAY_W-1:0]   rd_nxt;
  logic [ST_W-1:0]    st_nxt;

  assign busy = 1'b0;

  gdau_fwd #(.MAX_YEAR(MAX_YEAR)) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .func      (in_func),
    .year_a    (in_year_a),
    .month_a   (in_month_a),
    .day_a     (in_day_a),
    .year_b    (in_year_b),
    .month_b   (in_month_b),
    .day_b     (in_day_b),
    .day_count (in_day_count),
    .ctl_r     (ctl1),
    .ga_r      (ga1),
    .gb_r      (gb1),
    .cnt_r     (cnt1)
  );

  gdau_inv #(.MAX_YEAR(MAX_YEAR)) u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (ctl_r[2].vld),
    .g         (g2_r),
    .out_vld   (inv_vld),
    .out_year  (inv_year),
    .out_month (inv_month),
    .out_day   (inv_day),
    .out_ovf   (inv_ovf)
  );

  always_comb begin
    wk_prod = WP_W'(wx2_r) * WP_W'(WK_RECIP);
    q7_nxt  = G_W'(wk_prod >> WK_SHIFT);
    wd4_nxt = WD_W'(wx3_r - G_W'(q7_r * G_W'(7)));
  end

  always_comb begin
    vld_nxt  = ctl_r[6].vld;
    wd_nxt   = '0;
    diff_nxt = '0;
    ry_nxt   = '0;
    rm_nxt   = '0;
    rd_nxt   = '0;
    st_nxt   = ST_OK;
    if (ctl_r[6].bad) begin
      st_nxt = ST_BAD_DATE;
    end else begin
      case (ctl_r[6].func)
        FN_WEEKDAY: begin
          wd_nxt = wd_r[6];
        end
        FN_DIFF: begin
          diff_nxt = diff_r[6];
        end
        FN_ADD: begin
          if (inv_ovf) begin
            st_nxt = ST_RANGE;
          end else begin
            ry_nxt = YEAR_W'(inv_year);
            rm_nxt = inv_month;
            rd_nxt = inv_day;
          end
        end
        default: begin
          st_nxt = ST_BAD_DATE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 2; s <= 6; s++) begin
        ctl_r[s].vld <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      ctl_r[2].vld <= ctl1.vld;
      for (int s = 3; s <= 6; s++) begin
        ctl_r[s].vld <= ctl_r[s-1].vld;
      end
      out_valid <= vld_nxt;
    end
    ctl_r[2].bad  <= ctl1.bad;
    ctl_r[2].func <= ctl1.func;
    g2_r          <= ga1 + G_W'(cnt1);
    wx2_r         <= ga1 + G_W'(2);
    diff_r[2]     <= DIFF_W'(ga1 - gb1);
    for (int s = 3; s <= 6; s++) begin
      ctl_r[s].bad  <= ctl_r[s-1].bad;
      ctl_r[s].func <= ctl_r[s-1].func;
      diff_r[s]     <= diff_r[s-1];
    end
    wx3_r <= wx2_r;
    q7_r  <= q7_nxt;
    wd_r[4] <= wd4_nxt;
    wd_r[5] <= wd_r[4];
    wd_r[6] <= wd_r[5];
    out_weekday        <= wd_nxt;
    out_day_difference <= diff_nxt;
    out_result_year    <= ry_nxt;
    out_result_month   <= rm_nxt;
    out_result_day     <= rd_nxt;
    out_status         <= st_nxt;
  end

  a_inv_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    inv_vld == ctl_r[6].vld)
    else $error("date conversion valid out of step with control pipeline");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 7))
    else $error("result beat without a request seven cycles before");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday <= 3'd6))
    else $error("weekday out of range");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_weekday == '0 && out_day_difference == '0 && out_result_year == '0))
    else $error("error result carries nonzero fields");

endmodule
